// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define BLR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("blr assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low
`define BLR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("blr assertion failed");

`endif

// ----- rtl/blr_pkg.sv -----
`default_nettype none

package blr_pkg;

	// field widths
	localparam int COORD_W = 8;
	localparam int COL_W   = 6;
	localparam int ROW_W   = 4;
	localparam int COLOR_W = 24;
	localparam int ROT_W   = 2;

	// error term: holds sums of two 9-bit magnitudes with margin
	localparam int ERR_W = 11;

	// non-final words per line, and the counter for it
	localparam int MAX_NONFINAL = 36;
	localparam int CNT_W        = 6;

	localparam int PANEL_WIDTH_DEF  = 36;
	localparam int PANEL_HEIGHT_DEF = 16;

	// rotation codes, quarter turns
	localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
	localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
	localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
	localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RUN
	} blr_state_t;

	// sequencer to stepper
	typedef struct packed {
		logic load;
		logic adv;
	} blr_step_ctrl_t;

	// stepper to sequencer and mapper
	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic                      fin;
	} blr_point_t;

endpackage

`default_nettype wire

// ----- rtl/blr_step.sv -----
`default_nettype none

module blr_step (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire blr_pkg::blr_step_ctrl_t           ctrl,
	input  wire logic signed [blr_pkg::COORD_W-1:0] start_x,
	input  wire logic signed [blr_pkg::COORD_W-1:0] start_y,
	input  wire logic signed [blr_pkg::COORD_W-1:0] end_x,
	input  wire logic signed [blr_pkg::COORD_W-1:0] end_y,
	output blr_pkg::blr_point_t                    pt
);
	import blr_pkg::*;

	logic signed [COORD_W-1:0] x_q, y_q, xe_q, ye_q;
	logic signed [ERR_W-1:0]   err_q, dx_q, dy_q;
	logic                      sx_q, sy_q;

	logic signed [COORD_W:0]   dxs, dys;
	logic        [COORD_W:0]   adx, ady;
	logic signed [ERR_W-1:0]   dx_l, dy_l;
	logic signed [ERR_W:0]     e2;
	logic                      step_x, step_y;
	logic signed [ERR_W-1:0]   err_nxt;
	logic signed [COORD_W-1:0] x_nxt, y_nxt;

	// setup: signed deltas and their magnitudes from the endpoints
	always_comb begin
		dxs  = $signed({end_x[COORD_W-1], end_x}) - $signed({start_x[COORD_W-1], start_x});
		dys  = $signed({end_y[COORD_W-1], end_y}) - $signed({start_y[COORD_W-1], start_y});
		adx  = dxs[COORD_W] ? (COORD_W+1)'(-dxs) : dxs;
		ady  = dys[COORD_W] ? (COORD_W+1)'(-dys) : dys;
		dx_l = $signed({{(ERR_W-COORD_W-1){1'b0}}, adx});
		dy_l = -$signed({{(ERR_W-COORD_W-1){1'b0}}, ady});
	end

	// one error-term step
	always_comb begin
		e2      = $signed({err_q, 1'b0});
		step_x  = e2 >= $signed({dy_q[ERR_W-1], dy_q});
		step_y  = e2 <= $signed({dx_q[ERR_W-1], dx_q});
		err_nxt = err_q + (step_x ? dy_q : '0) + (step_y ? dx_q : '0);
		x_nxt   = x_q;
		y_nxt   = y_q;
		if (step_x) begin
			x_nxt = sx_q ? x_q + COORD_W'(1) : x_q - COORD_W'(1);
		end
		if (step_y) begin
			y_nxt = sy_q ? y_q + COORD_W'(1) : y_q - COORD_W'(1);
		end
	end

	// walker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q   <= '0;
			y_q   <= '0;
			xe_q  <= '0;
			ye_q  <= '0;
			err_q <= '0;
			dx_q  <= '0;
			dy_q  <= '0;
			sx_q  <= 1'b0;
			sy_q  <= 1'b0;
		end else if (ctrl.load) begin
			x_q   <= start_x;
			y_q   <= start_y;
			xe_q  <= end_x;
			ye_q  <= end_y;
			dx_q  <= dx_l;
			dy_q  <= dy_l;
			err_q <= dx_l + dy_l;
			sx_q  <= start_x < end_x;
			sy_q  <= start_y < end_y;
		end else if (ctrl.adv) begin
			x_q   <= x_nxt;
			y_q   <= y_nxt;
			err_q <= err_nxt;
		end
	end

	assign pt.x   = x_q;
	assign pt.y   = y_q;
	assign pt.fin = (x_q == xe_q) && (y_q == ye_q);

endmodule

`default_nettype wire

// ----- rtl/blr_map.sv -----
`default_nettype none

module blr_map #(
	parameter int PANEL_WIDTH  = blr_pkg::PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = blr_pkg::PANEL_HEIGHT_DEF
) (
	input  wire blr_pkg::blr_point_t            pt,
	input  wire logic [blr_pkg::ROT_W-1:0]      rotation,
	output logic                                vis,
	output logic [blr_pkg::COL_W-1:0]           col,
	output logic [blr_pkg::ROW_W-1:0]           row
);
	import blr_pkg::*;

	localparam logic [COORD_W-1:0] PW    = COORD_W'(PANEL_WIDTH);
	localparam logic [COORD_W-1:0] PH    = COORD_W'(PANEL_HEIGHT);
	localparam logic [COORD_W-1:0] PW_M1 = COORD_W'(PANEL_WIDTH - 1);
	localparam logic [COORD_W-1:0] PH_M1 = COORD_W'(PANEL_HEIGHT - 1);

	logic [COORD_W-1:0] lw, lh, ux, uy, c, r;

	// clip against the logical panel, then rotate into the frame buffer
	always_comb begin
		lw  = rotation[0] ? PH : PW;
		lh  = rotation[0] ? PW : PH;
		ux  = {1'b0, pt.x[COORD_W-2:0]};
		uy  = {1'b0, pt.y[COORD_W-2:0]};
		vis = !pt.x[COORD_W-1] && !pt.y[COORD_W-1] && (ux < lw) && (uy < lh);
		case (rotation)
			ROT_90: begin
				c = PW_M1 - uy;
				r = ux;
			end
			ROT_180: begin
				c = PW_M1 - ux;
				r = PH_M1 - uy;
			end
			ROT_270: begin
				c = uy;
				r = PH_M1 - ux;
			end
			default: begin
				c = ux;
				r = uy;
			end
		endcase
		col = c[COL_W-1:0];
		row = r[ROW_W-1:0];
	end

endmodule

`default_nettype wire

// ----- rtl/bresenham_line_rasterizer_core.sv -----
`default_nettype none

// Line rasterizer: takes one line command (signed start and end points, packed RGB) and
// walks the error-term line one point per cycle while the output is not blocked, giving
// one frame-buffer write word per visible point, up to 36 non-final words per line,
// clipped to the logical panel and rotated by the rotation register. The final point's
// word has last set; if that point is off screen its write_enable, fb_col, fb_row and
// out_color are zero. A line has max(|dx|,|dy|)+1 points, so 1 to 256, walked by the
// single error-term stepper; it stalls while a word waits on out_ready. in_ready is
// low while a line is being walked. Rotation is written through cfg_we/cfg_wdata.
module bresenham_line_rasterizer_core #(
	parameter int PANEL_WIDTH  = blr_pkg::PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = blr_pkg::PANEL_HEIGHT_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [blr_pkg::ROT_W-1:0]          cfg_wdata,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic signed [blr_pkg::COORD_W-1:0] start_x,
	input  wire logic signed [blr_pkg::COORD_W-1:0] start_y,
	input  wire logic signed [blr_pkg::COORD_W-1:0] end_x,
	input  wire logic signed [blr_pkg::COORD_W-1:0] end_y,
	input  wire logic [blr_pkg::COLOR_W-1:0]        pixel_color,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic                                    write_enable,
	output logic [blr_pkg::COL_W-1:0]               fb_col,
	output logic [blr_pkg::ROW_W-1:0]               fb_row,
	output logic [blr_pkg::COLOR_W-1:0]             out_color,
	output logic                                    last
);
	import blr_pkg::*;

	blr_state_t           state_q, state_d;
	logic [ROT_W-1:0]     rotation_q;
	logic [COLOR_W-1:0]   color_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 out_valid_q;
	logic                 we_q, last_q;
	logic [COL_W-1:0]     col_q;
	logic [ROW_W-1:0]     row_q;
	logic [COLOR_W-1:0]   ocolor_q;

	blr_step_ctrl_t       ctrl;
	blr_point_t           pt;
	logic                 vis;
	logic [COL_W-1:0]     col;
	logic [ROW_W-1:0]     row;
	logic                 emit, out_free, go;

	blr_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.start_x (start_x),
		.start_y (start_y),
		.end_x   (end_x),
		.end_y   (end_y),
		.pt      (pt)
	);

	blr_map #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT)
	) u_map (
		.pt       (pt),
		.rotation (rotation_q),
		.vis      (vis),
		.col      (col),
		.row      (row)
	);

	// rotation register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q <= ROT_0;
		end else if (cfg_we) begin
			rotation_q <= cfg_wdata;
		end
	end

	// sequencer: load a command, then one point per cycle unless the output is blocked
	always_comb begin
		out_free  = !out_valid_q || out_ready;
		emit      = pt.fin || (vis && (cnt_q < CNT_W'(MAX_NONFINAL)));
		go        = 1'b0;
		state_d   = state_q;
		in_ready  = 1'b0;
		ctrl.load = 1'b0;
		ctrl.adv  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				ctrl.load = in_valid;
				if (in_valid) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				go       = !emit || out_free;
				ctrl.adv = go && !pt.fin;
				if (go && pt.fin) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (ctrl.load) begin
				cnt_q <= '0;
			end else if (go && emit && !pt.fin) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// command color
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			color_q <= pixel_color;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			we_q     <= vis;
			last_q   <= pt.fin;
			col_q    <= vis ? col : '0;
			row_q    <= vis ? row : '0;
			ocolor_q <= vis ? color_q : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign write_enable = we_q;
	assign last         = last_q;
	assign fb_col       = col_q;
	assign fb_row       = row_q;
	assign out_color    = ocolor_q;

`include "assert_macros.svh"

	// a word without a write can only be the final one
	`BLR_ASSERT_IMP(a_nowrite_is_last, out_valid_q && !we_q, last_q)
	// a suppressed write carries zero position and color
	`BLR_ASSERT_IMP(a_nowrite_zero, out_valid_q && !we_q, {col_q, row_q, ocolor_q} == '0)
	// an accepted command starts a walk
	`BLR_ASSERT_NXT(a_load_runs, in_valid && in_ready, state_q == ST_RUN)
	// non-final word count never exceeds the limit
	`BLR_ASSERT_IMP(a_cnt_limit, state_q == ST_RUN, cnt_q <= CNT_W'(MAX_NONFINAL))

endmodule

`default_nettype wire
